>>> rtl/core/rfr_pkg.sv
// rfr_pkg: shared types and constants of the radar frame receiver
// used by radar_frame_receiver and the testbench; no dependencies
`default_nettype none

package rfr_pkg;

    localparam int BUFFER_BYTES = 64;
    localparam int GATE_COUNT   = 9;

    localparam int ADDR_W = $clog2(BUFFER_BYTES);
    localparam int CNT_W  = $clog2(BUFFER_BYTES + 1);
    localparam int LEN_W  = 9;
    localparam int GATE_W = 4;

    // header and footer patterns, first byte on the link in the top byte
    localparam logic [31:0] TGT_HEAD = 32'hF4F3F2F1;
    localparam logic [31:0] CFG_HEAD = 32'hFDFCFBFA;
    localparam logic [31:0] TGT_FOOT = 32'hF8F7F6F5;
    localparam logic [31:0] CFG_FOOT = 32'h04030201;

    localparam logic [LEN_W-1:0] LEN_EXTRA = 9'd10;

    localparam logic [7:0] LEN_BASIC  = 8'h0D;
    localparam logic [7:0] LEN_ENG    = 8'h23;
    localparam logic [7:0] TAIL_MARK  = 8'h55;
    localparam logic [7:0] TYPE_BASIC = 8'h02;
    localparam logic [7:0] TYPE_ENG   = 8'h01;
    localparam logic [7:0] CMD_PARAM  = 8'h61;
    localparam logic [7:0] CMD_ACK    = 8'hFF;

    // result kinds
    localparam logic [2:0] KIND_REPORT = 3'd0;
    localparam logic [2:0] KIND_MOVING = 3'd1;
    localparam logic [2:0] KIND_STATIC = 3'd2;
    localparam logic [2:0] KIND_LIGHT  = 3'd3;
    localparam logic [2:0] KIND_PARAM  = 3'd4;
    localparam logic [2:0] KIND_SENS   = 3'd5;
    localparam logic [2:0] KIND_ACK    = 3'd6;

    // base addresses of the per-gate byte runs
    localparam logic [ADDR_W-1:0] MOV_BASE    = ADDR_W'(19);
    localparam logic [ADDR_W-1:0] STA_BASE    = ADDR_W'(28);
    localparam logic [ADDR_W-1:0] SENS_A_BASE = ADDR_W'(14);
    localparam logic [ADDR_W-1:0] SENS_B_BASE = ADDR_W'(23);

    // bytes fetched from the store before decode, by slot
    localparam int FETCH_COUNT = 17;
    localparam int FIDX_W      = $clog2(FETCH_COUNT + 1);

    localparam logic [FIDX_W-1:0] FB_B6  = FIDX_W'(0);
    localparam logic [FIDX_W-1:0] FB_B8  = FIDX_W'(1);
    localparam logic [FIDX_W-1:0] FB_B9  = FIDX_W'(2);
    localparam logic [FIDX_W-1:0] FB_B10 = FIDX_W'(3);
    localparam logic [FIDX_W-1:0] FB_B11 = FIDX_W'(4);
    localparam logic [FIDX_W-1:0] FB_B12 = FIDX_W'(5);
    localparam logic [FIDX_W-1:0] FB_B13 = FIDX_W'(6);
    localparam logic [FIDX_W-1:0] FB_B14 = FIDX_W'(7);
    localparam logic [FIDX_W-1:0] FB_B15 = FIDX_W'(8);
    localparam logic [FIDX_W-1:0] FB_B16 = FIDX_W'(9);
    localparam logic [FIDX_W-1:0] FB_B17 = FIDX_W'(10);
    localparam logic [FIDX_W-1:0] FB_B18 = FIDX_W'(11);
    localparam logic [FIDX_W-1:0] FB_B37 = FIDX_W'(12);
    localparam logic [FIDX_W-1:0] FB_B38 = FIDX_W'(13);
    localparam logic [FIDX_W-1:0] FB_B39 = FIDX_W'(14);
    localparam logic [FIDX_W-1:0] FB_B32 = FIDX_W'(15);
    localparam logic [FIDX_W-1:0] FB_B33 = FIDX_W'(16);

    function automatic logic [ADDR_W-1:0] fetch_addr(input logic [FIDX_W-1:0] idx);
        logic [ADDR_W-1:0] a;
        a = '0;
        unique case (idx)
            FB_B6:   a = ADDR_W'(6);
            FB_B8:   a = ADDR_W'(8);
            FB_B9:   a = ADDR_W'(9);
            FB_B10:  a = ADDR_W'(10);
            FB_B11:  a = ADDR_W'(11);
            FB_B12:  a = ADDR_W'(12);
            FB_B13:  a = ADDR_W'(13);
            FB_B14:  a = ADDR_W'(14);
            FB_B15:  a = ADDR_W'(15);
            FB_B16:  a = ADDR_W'(16);
            FB_B17:  a = ADDR_W'(17);
            FB_B18:  a = ADDR_W'(18);
            FB_B37:  a = ADDR_W'(37);
            FB_B38:  a = ADDR_W'(38);
            FB_B39:  a = ADDR_W'(39);
            FB_B32:  a = ADDR_W'(32);
            FB_B33:  a = ADDR_W'(33);
            default: a = '0;
        endcase
        return a;
    endfunction

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EVAL,
        ST_REPORT,
        ST_MOV_RD,
        ST_MOV_EMIT,
        ST_STA_RD,
        ST_STA_EMIT,
        ST_LIGHT,
        ST_PARAM,
        ST_SENS_RDA,
        ST_SENS_RDB,
        ST_SENS_EMIT,
        ST_ACK
    } state_t;

endpackage

`default_nettype wire

>>> rtl/core/rfr_ram.sv
// rfr_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module rfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/radar_frame_receiver.sv
// radar_frame_receiver: byte-serial frame receiver and decoder for a radar link
// depends on rfr_pkg and rfr_ram
//
// s_ channel: one received byte per transfer (s_rx_byte). m_ channel: decoded
// results, one per transfer, m_last marks the final result caused by a byte.
// A byte that does not complete a frame leaves s_ready high. A byte that
// completes a frame with a good footer starts a decode pass: fetching fields
// from the frame store (one read port, one byte per cycle), an evaluation
// state, then the results. A target frame gives a report and, if engineering,
// each gate energy (a store read, then an emit) and light/pin; a config frame
// gives parameters and each gate sensitivity (two store reads, then an emit)
// or an ack. The first result is visible in the cycle after it is produced.
// s_ready stays low for the whole decode pass. When the receiver stalls, the
// sequencer holds at the current result until the output register is taken.
// Synchronous reset clears the byte count, header copy and per-entry valid
// bits of the store (unwritten entries read as zero) and drops m_valid.
`default_nettype none

module radar_frame_receiver (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_kind,
    output logic [3:0]       m_gate,
    output logic [15:0]      m_word_a,
    output logic [7:0]       m_byte_a,
    output logic [15:0]      m_word_b,
    output logic [7:0]       m_byte_b,
    output logic [15:0]      m_word_c,
    output logic             m_engineering,
    output logic             m_last
);

    localparam int AW = rfr_pkg::ADDR_W;
    localparam int CW = rfr_pkg::CNT_W;
    localparam int FW = rfr_pkg::FIDX_W;
    localparam int GW = rfr_pkg::GATE_W;
    localparam int LW = rfr_pkg::LEN_W;

    rfr_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                    count_reg, count_next;
    logic [31:0]                      hist_reg, hist_next;
    logic [7:0]                       hdr_reg [5];
    logic [7:0]                       hdr_next [5];
    logic [rfr_pkg::BUFFER_BYTES-1:0] valid_reg, valid_next;
    logic [FW-1:0]                    fidx_reg, fidx_next;
    logic [GW-1:0]                    gate_reg, gate_next;
    logic                             tgt_reg, tgt_next;
    logic [7:0]                       tmp_reg, tmp_next;
    logic [7:0]                       fb_reg [rfr_pkg::FETCH_COUNT];
    logic                             rvalid_reg;

    logic          accept;
    logic [CW-1:0] pos, c1;
    logic [AW-1:0] waddr;
    logic [LW-1:0] len;
    logic [31:0]   hdr_word;
    logic          fb_we;
    logic [FW-1:0] fb_widx;
    logic          re;
    logic [AW-1:0] raddr;
    logic [7:0]    ram_q, rdata;

    logic        out_free, ld;
    logic [2:0]  ld_kind;
    logic [3:0]  ld_gate;
    logic [15:0] ld_word_a, ld_word_b, ld_word_c;
    logic [7:0]  ld_byte_a, ld_byte_b;
    logic        ld_eng, ld_last;

    logic [7:0] b6, b8, b17, b18;
    logic       tgt_ok;

    logic        m_valid_reg;
    logic [2:0]  m_kind_reg;
    logic [3:0]  m_gate_reg;
    logic [15:0] m_word_a_reg, m_word_b_reg, m_word_c_reg;
    logic [7:0]  m_byte_a_reg, m_byte_b_reg;
    logic        m_eng_reg, m_last_reg;

    assign s_ready  = (state_reg == rfr_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign pos      = (count_reg >= CW'(rfr_pkg::BUFFER_BYTES)) ? '0 : count_reg;
    assign c1       = pos + CW'(1);
    assign waddr    = pos[AW-1:0];
    assign len      = {1'b0, hdr_reg[4]} + rfr_pkg::LEN_EXTRA;
    assign hdr_word = {hdr_reg[0], hdr_reg[1], hdr_reg[2], hdr_reg[3]};
    assign rdata    = ram_q & {8{rvalid_reg}};
    assign out_free = !m_valid_reg || m_ready;

    assign b6  = fb_reg[rfr_pkg::FB_B6];
    assign b8  = fb_reg[rfr_pkg::FB_B8];
    assign b17 = fb_reg[rfr_pkg::FB_B17];
    assign b18 = fb_reg[rfr_pkg::FB_B18];
    assign tgt_ok = (hdr_reg[4] == rfr_pkg::LEN_BASIC && b17 == rfr_pkg::TAIL_MARK
                     && b6 == rfr_pkg::TYPE_BASIC)
                 || (hdr_reg[4] == rfr_pkg::LEN_ENG
                     && fb_reg[rfr_pkg::FB_B39] == rfr_pkg::TAIL_MARK
                     && b6 == rfr_pkg::TYPE_ENG);

    rfr_ram #(
        .WIDTH(8),
        .DEPTH(rfr_pkg::BUFFER_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (accept),
        .waddr (waddr),
        .wdata (s_rx_byte),
        .re    (re),
        .raddr (raddr),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rfr_pkg::ST_IDLE;
            count_reg <= '0;
            valid_reg <= '0;
            for (int i = 0; i < 5; i++) begin
                hdr_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
            for (int i = 0; i < 5; i++) begin
                hdr_reg[i] <= hdr_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        hist_reg <= hist_next;
        fidx_reg <= fidx_next;
        gate_reg <= gate_next;
        tgt_reg  <= tgt_next;
        tmp_reg  <= tmp_next;
        if (re) begin
            rvalid_reg <= valid_reg[raddr];
        end
        if (fb_we) begin
            fb_reg[fb_widx] <= rdata;
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        hist_next  = hist_reg;
        valid_next = valid_reg;
        for (int i = 0; i < 5; i++) begin
            hdr_next[i] = hdr_reg[i];
        end
        fidx_next = fidx_reg;
        gate_next = gate_reg;
        tgt_next  = tgt_reg;
        tmp_next  = tmp_reg;
        fb_we     = 1'b0;
        fb_widx   = fidx_reg - FW'(1);
        re        = 1'b0;
        raddr     = rfr_pkg::fetch_addr(fidx_reg);
        ld        = 1'b0;
        ld_kind   = rfr_pkg::KIND_REPORT;
        ld_gate   = '0;
        ld_word_a = '0;
        ld_byte_a = '0;
        ld_word_b = '0;
        ld_byte_b = '0;
        ld_word_c = '0;
        ld_eng    = 1'b0;
        ld_last   = 1'b0;

        unique case (state_reg)
            rfr_pkg::ST_IDLE: begin
                if (accept) begin
                    hist_next         = {hist_reg[23:0], s_rx_byte};
                    valid_next[waddr] = 1'b1;
                    if (pos < CW'(5)) begin
                        hdr_next[pos[2:0]] = s_rx_byte;
                    end
                    count_next = c1;
                    if (c1 >= CW'(5) && (hist_next == rfr_pkg::TGT_HEAD
                                         || hist_next == rfr_pkg::CFG_HEAD)) begin
                        // resync: last four bytes become the frame start
                        hdr_next[0] = hist_next[31:24];
                        hdr_next[1] = hist_next[23:16];
                        hdr_next[2] = hist_next[15:8];
                        hdr_next[3] = hist_next[7:0];
                        count_next  = CW'(4);
                    end else if (c1 >= CW'(6)) begin
                        if (hdr_word != rfr_pkg::TGT_HEAD && hdr_word != rfr_pkg::CFG_HEAD) begin
                            count_next = '0;
                        end else if (len > LW'(rfr_pkg::BUFFER_BYTES)) begin
                            count_next = '0;
                        end else if (LW'(c1) >= len) begin
                            count_next = '0;
                            tgt_next   = (hdr_word == rfr_pkg::TGT_HEAD);
                            if ((hdr_word == rfr_pkg::TGT_HEAD && hist_next == rfr_pkg::TGT_FOOT)
                                || (hdr_word == rfr_pkg::CFG_HEAD
                                    && hist_next == rfr_pkg::CFG_FOOT)) begin
                                fidx_next  = '0;
                                state_next = rfr_pkg::ST_FETCH;
                            end
                        end
                    end
                end
            end
            rfr_pkg::ST_FETCH: begin
                re        = (fidx_reg < FW'(rfr_pkg::FETCH_COUNT));
                fb_we     = (fidx_reg != '0);
                fidx_next = fidx_reg + FW'(1);
                if (fidx_reg == FW'(rfr_pkg::FETCH_COUNT)) begin
                    state_next = rfr_pkg::ST_EVAL;
                end
            end
            rfr_pkg::ST_EVAL: begin
                gate_next = '0;
                if (tgt_reg) begin
                    state_next = tgt_ok ? rfr_pkg::ST_REPORT : rfr_pkg::ST_IDLE;
                end else if (b6 == rfr_pkg::CMD_PARAM) begin
                    state_next = rfr_pkg::ST_PARAM;
                end else if (b6 == rfr_pkg::CMD_ACK) begin
                    state_next = rfr_pkg::ST_ACK;
                end else begin
                    state_next = rfr_pkg::ST_IDLE;
                end
            end
            rfr_pkg::ST_REPORT: begin
                if (out_free) begin
                    ld      = 1'b1;
                    ld_kind = rfr_pkg::KIND_REPORT;
                    ld_eng  = (b6 == rfr_pkg::TYPE_ENG);
                    ld_last = (b6 != rfr_pkg::TYPE_ENG);
                    if (b8 != 8'h00) begin
                        ld_word_a = {fb_reg[rfr_pkg::FB_B10], fb_reg[rfr_pkg::FB_B9]};
                        ld_byte_a = fb_reg[rfr_pkg::FB_B11];
                        ld_word_b = {fb_reg[rfr_pkg::FB_B13], fb_reg[rfr_pkg::FB_B12]};
                        ld_byte_b = fb_reg[rfr_pkg::FB_B14];
                        ld_word_c = {fb_reg[rfr_pkg::FB_B16], fb_reg[rfr_pkg::FB_B15]};
                    end
                    if (b6 != rfr_pkg::TYPE_ENG) begin
                        state_next = rfr_pkg::ST_IDLE;
                    end else if (b17 < 8'(rfr_pkg::GATE_COUNT)) begin
                        state_next = rfr_pkg::ST_MOV_RD;
                    end else if (b18 < 8'(rfr_pkg::GATE_COUNT)) begin
                        state_next = rfr_pkg::ST_STA_RD;
                    end else begin
                        state_next = rfr_pkg::ST_LIGHT;
                    end
                end
            end
            rfr_pkg::ST_MOV_RD: begin
                re         = 1'b1;
                raddr      = rfr_pkg::MOV_BASE + AW'(gate_reg);
                state_next = rfr_pkg::ST_MOV_EMIT;
            end
            rfr_pkg::ST_MOV_EMIT: begin
                if (out_free) begin
                    ld        = 1'b1;
                    ld_kind   = rfr_pkg::KIND_MOVING;
                    ld_gate   = gate_reg;
                    ld_byte_a = rdata;
                    if (8'(gate_reg) == b17) begin
                        gate_next = '0;
                        if (b18 < 8'(rfr_pkg::GATE_COUNT)) begin
                            state_next = rfr_pkg::ST_STA_RD;
                        end else begin
                            state_next = rfr_pkg::ST_LIGHT;
                        end
                    end else begin
                        gate_next  = gate_reg + GW'(1);
                        state_next = rfr_pkg::ST_MOV_RD;
                    end
                end
            end
            rfr_pkg::ST_STA_RD: begin
                re         = 1'b1;
                raddr      = rfr_pkg::STA_BASE + AW'(gate_reg);
                state_next = rfr_pkg::ST_STA_EMIT;
            end
            rfr_pkg::ST_STA_EMIT: begin
                if (out_free) begin
                    ld        = 1'b1;
                    ld_kind   = rfr_pkg::KIND_STATIC;
                    ld_gate   = gate_reg;
                    ld_byte_b = rdata;
                    if (8'(gate_reg) == b18) begin
                        state_next = rfr_pkg::ST_LIGHT;
                    end else begin
                        gate_next  = gate_reg + GW'(1);
                        state_next = rfr_pkg::ST_STA_RD;
                    end
                end
            end
            rfr_pkg::ST_LIGHT: begin
                if (out_free) begin
                    ld         = 1'b1;
                    ld_kind    = rfr_pkg::KIND_LIGHT;
                    ld_byte_a  = fb_reg[rfr_pkg::FB_B37];
                    ld_byte_b  = fb_reg[rfr_pkg::FB_B38];
                    ld_last    = 1'b1;
                    state_next = rfr_pkg::ST_IDLE;
                end
            end
            rfr_pkg::ST_PARAM: begin
                if (out_free) begin
                    ld         = 1'b1;
                    ld_kind    = rfr_pkg::KIND_PARAM;
                    ld_byte_a  = fb_reg[rfr_pkg::FB_B12];
                    ld_byte_b  = fb_reg[rfr_pkg::FB_B13];
                    ld_word_c  = {fb_reg[rfr_pkg::FB_B33], fb_reg[rfr_pkg::FB_B32]};
                    gate_next  = '0;
                    state_next = rfr_pkg::ST_SENS_RDA;
                end
            end
            rfr_pkg::ST_SENS_RDA: begin
                re         = 1'b1;
                raddr      = rfr_pkg::SENS_A_BASE + AW'(gate_reg);
                state_next = rfr_pkg::ST_SENS_RDB;
            end
            rfr_pkg::ST_SENS_RDB: begin
                re         = 1'b1;
                raddr      = rfr_pkg::SENS_B_BASE + AW'(gate_reg);
                tmp_next   = rdata;
                state_next = rfr_pkg::ST_SENS_EMIT;
            end
            rfr_pkg::ST_SENS_EMIT: begin
                if (out_free) begin
                    ld        = 1'b1;
                    ld_kind   = rfr_pkg::KIND_SENS;
                    ld_gate   = gate_reg;
                    ld_byte_a = tmp_reg;
                    ld_byte_b = rdata;
                    if (gate_reg == GW'(rfr_pkg::GATE_COUNT - 1)) begin
                        ld_last    = 1'b1;
                        state_next = rfr_pkg::ST_IDLE;
                    end else begin
                        gate_next  = gate_reg + GW'(1);
                        state_next = rfr_pkg::ST_SENS_RDA;
                    end
                end
            end
            rfr_pkg::ST_ACK: begin
                if (out_free) begin
                    ld         = 1'b1;
                    ld_kind    = rfr_pkg::KIND_ACK;
                    ld_last    = 1'b1;
                    state_next = rfr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rfr_pkg::ST_IDLE;
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ld) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            m_kind_reg   <= ld_kind;
            m_gate_reg   <= ld_gate;
            m_word_a_reg <= ld_word_a;
            m_byte_a_reg <= ld_byte_a;
            m_word_b_reg <= ld_word_b;
            m_byte_b_reg <= ld_byte_b;
            m_word_c_reg <= ld_word_c;
            m_eng_reg    <= ld_eng;
            m_last_reg   <= ld_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_gate        = m_gate_reg;
    assign m_word_a      = m_word_a_reg;
    assign m_byte_a      = m_byte_a_reg;
    assign m_word_b      = m_word_b_reg;
    assign m_byte_b      = m_byte_b_reg;
    assign m_word_c      = m_word_c_reg;
    assign m_engineering = m_eng_reg;
    assign m_last        = m_last_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(rfr_pkg::BUFFER_BYTES))
        else $error("byte count beyond store size");

    a_gate_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rfr_pkg::ST_MOV_EMIT || state_reg == rfr_pkg::ST_STA_EMIT
         || state_reg == rfr_pkg::ST_SENS_EMIT) |-> gate_reg < GW'(rfr_pkg::GATE_COUNT))
        else $error("gate index out of range");

    a_report_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == rfr_pkg::KIND_REPORT) |-> (m_last == !m_engineering))
        else $error("report last flag disagrees with frame type");

    a_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == rfr_pkg::ST_IDLE
                                  || state_reg == rfr_pkg::ST_FETCH))
        else $error("byte transfer led to unexpected state");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// tb: self-checking testbench for radar_frame_receiver, feeds target, config, broken and noise
// byte streams and checks every decoded result against an in-bench frame decoder
// depends on rfr_pkg and the radar_frame_receiver rtl
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT = 40_000;
    localparam int BYTE_TARGET = 250;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  gate;
        logic [15:0] word_a;
        logic [7:0]  byte_a;
        logic [15:0] word_b;
        logic [7:0]  byte_b;
        logic [15:0] word_c;
        logic        engineering;
        logic        last;
    } radar_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_kind;
    logic [3:0]  m_gate;
    logic [15:0] m_word_a;
    logic [7:0]  m_byte_a;
    logic [15:0] m_word_b;
    logic [7:0]  m_byte_b;
    logic [15:0] m_word_c;
    logic        m_engineering;
    logic        m_last;

    logic [7:0]    shadow_frame [rfr_pkg::BUFFER_BYTES] = '{default: 8'h00};
    int            shadow_count = 0;
    radar_result_t decoded[$];
    radar_result_t pending_results[$];
    logic [7:0]    tx_frame[$];

    int mismatch_count = 0;
    int bytes_accepted = 0;
    int cycle_count = 0;
    bit steady_mode = 1'b0;

    radar_frame_receiver u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_gate        (m_gate),
        .m_word_a      (m_word_a),
        .m_byte_a      (m_byte_a),
        .m_word_b      (m_word_b),
        .m_byte_b      (m_byte_b),
        .m_word_c      (m_word_c),
        .m_engineering (m_engineering),
        .m_last        (m_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t, %s: got %0h expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // frame decoder kept alongside the dut

    function automatic logic [7:0] shadow_rd(input int idx);
        return (idx < rfr_pkg::BUFFER_BYTES) ? shadow_frame[idx] : 8'h00;
    endfunction

    function automatic bit shadow_match(input logic [31:0] pat, input int off);
        return shadow_rd(off) == pat[31:24] && shadow_rd(off + 1) == pat[23:16] &&
               shadow_rd(off + 2) == pat[15:8] && shadow_rd(off + 3) == pat[7:0];
    endfunction

    function automatic void add_result(input logic [2:0] kind, input logic [3:0] gate,
                                       input logic [15:0] wa, input logic [7:0] ba,
                                       input logic [15:0] wb, input logic [7:0] bb,
                                       input logic [15:0] wc, input logic eng);
        radar_result_t r;
        r.kind = kind;
        r.gate = gate;
        r.word_a = wa;
        r.byte_a = ba;
        r.word_b = wb;
        r.byte_b = bb;
        r.word_c = wc;
        r.engineering = eng;
        r.last = 1'b0;
        decoded.insert(decoded.size(), r);
    endfunction

    function automatic void decode_target_frame();
        logic [15:0] mov_dist, sta_dist, det_dist;
        logic [7:0]  mov_energy, sta_energy;
        bit          basic_ok, eng_ok, is_eng;
        int          g;
        basic_ok = shadow_rd(4) == rfr_pkg::LEN_BASIC &&
                   shadow_rd(17) == rfr_pkg::TAIL_MARK &&
                   shadow_rd(6) == rfr_pkg::TYPE_BASIC;
        eng_ok = shadow_rd(4) == rfr_pkg::LEN_ENG &&
                 shadow_rd(39) == rfr_pkg::TAIL_MARK &&
                 shadow_rd(6) == rfr_pkg::TYPE_ENG;
        is_eng = shadow_rd(6) == rfr_pkg::TYPE_ENG;
        mov_dist = '0;
        sta_dist = '0;
        det_dist = '0;
        mov_energy = '0;
        sta_energy = '0;
        if (!basic_ok && !eng_ok)
            return;
        if (shadow_rd(8) != 8'h00) begin
            mov_dist = {shadow_rd(10), shadow_rd(9)};
            mov_energy = shadow_rd(11);
            sta_dist = {shadow_rd(13), shadow_rd(12)};
            sta_energy = shadow_rd(14);
            det_dist = {shadow_rd(16), shadow_rd(15)};
        end
        add_result(rfr_pkg::KIND_REPORT, '0, mov_dist, mov_energy, sta_dist, sta_energy,
                   det_dist, is_eng);
        if (is_eng) begin
            if (shadow_rd(17) < rfr_pkg::GATE_COUNT)
                for (g = 0; g <= int'(shadow_rd(17)); g++)
                    add_result(rfr_pkg::KIND_MOVING, 4'(g), '0,
                               shadow_rd(int'(rfr_pkg::MOV_BASE) + g), '0, '0, '0, 1'b0);
            if (shadow_rd(18) < rfr_pkg::GATE_COUNT)
                for (g = 0; g <= int'(shadow_rd(18)); g++)
                    add_result(rfr_pkg::KIND_STATIC, 4'(g), '0, '0, '0,
                               shadow_rd(int'(rfr_pkg::STA_BASE) + g), '0, 1'b0);
            add_result(rfr_pkg::KIND_LIGHT, '0, '0, shadow_rd(37), '0, shadow_rd(38), '0, 1'b0);
        end
    endfunction

    function automatic void decode_config_frame();
        int g;
        if (shadow_rd(6) == rfr_pkg::CMD_PARAM) begin
            add_result(rfr_pkg::KIND_PARAM, '0, '0, shadow_rd(12), '0, shadow_rd(13),
                       {shadow_rd(33), shadow_rd(32)}, 1'b0);
            for (g = 0; g < rfr_pkg::GATE_COUNT; g++)
                add_result(rfr_pkg::KIND_SENS, 4'(g), '0,
                           shadow_rd(int'(rfr_pkg::SENS_A_BASE) + g), '0,
                           shadow_rd(int'(rfr_pkg::SENS_B_BASE) + g), '0, 1'b0);
        end else if (shadow_rd(6) == rfr_pkg::CMD_ACK) begin
            add_result(rfr_pkg::KIND_ACK, '0, '0, '0, '0, '0, '0, 1'b0);
        end
    endfunction

    function automatic void predict_rx_byte(input logic [7:0] rx);
        int start, frame_len, k;
        bit tgt_front, cfg_front;
        decoded.delete();
        if (shadow_count >= rfr_pkg::BUFFER_BYTES)
            shadow_count = 0;
        shadow_frame[shadow_count] = rx;
        shadow_count++;
        if (shadow_count >= 4) begin
            start = shadow_count - 4;
            // a header at the tail restarts the frame
            if (start != 0 && (shadow_match(rfr_pkg::TGT_HEAD, start)
                               || shadow_match(rfr_pkg::CFG_HEAD, start))) begin
                for (k = 0; k < 4; k++)
                    shadow_frame[k] = shadow_frame[start + k];
                shadow_count = 4;
            end
            if (shadow_count >= 6) begin
                tgt_front = shadow_match(rfr_pkg::TGT_HEAD, 0);
                cfg_front = shadow_match(rfr_pkg::CFG_HEAD, 0);
                if (tgt_front || cfg_front) begin
                    frame_len = int'(shadow_rd(4)) + 10;
                    if (frame_len > rfr_pkg::BUFFER_BYTES) begin
                        shadow_count = 0;
                    end else if (shadow_count >= frame_len) begin
                        if (tgt_front) begin
                            if (shadow_match(rfr_pkg::TGT_FOOT, frame_len - 4))
                                decode_target_frame();
                        end else if (shadow_match(rfr_pkg::CFG_FOOT, frame_len - 4)) begin
                            decode_config_frame();
                        end
                        shadow_count = 0;
                    end
                end else begin
                    shadow_count = 0;
                end
            end
        end
        if (decoded.size() > 0)
            decoded[decoded.size() - 1].last = 1'b1;
        foreach (decoded[i])
            pending_results.insert(pending_results.size(), decoded[i]);
    endfunction

    // result side

    always @(negedge aclk)
        m_ready <= steady_mode ? 1'b1 : ($urandom_range(99) >= 7);

    always @(posedge aclk) begin : result_check
        radar_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected, kind", m_kind, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_kind !== want.kind)
                    report_mismatch("kind", m_kind, want.kind);
                if (m_gate !== want.gate)
                    report_mismatch("gate", m_gate, want.gate);
                if (m_word_a !== want.word_a)
                    report_mismatch("word_a", m_word_a, want.word_a);
                if (m_byte_a !== want.byte_a)
                    report_mismatch("byte_a", m_byte_a, want.byte_a);
                if (m_word_b !== want.word_b)
                    report_mismatch("word_b", m_word_b, want.word_b);
                if (m_byte_b !== want.byte_b)
                    report_mismatch("byte_b", m_byte_b, want.byte_b);
                if (m_word_c !== want.word_c)
                    report_mismatch("word_c", m_word_c, want.word_c);
                if (m_engineering !== want.engineering)
                    report_mismatch("engineering", m_engineering, want.engineering);
                if (m_last !== want.last)
                    report_mismatch("last", m_last, want.last);
            end
        end
    end

    // byte side

    task automatic send_byte(input logic [7:0] rx);
        @(negedge aclk);
        while (!steady_mode && $urandom_range(99) < 7) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= rx;
        do
            @(posedge aclk);
        while (!s_ready);
        // transfer done
        predict_rx_byte(rx);
        bytes_accepted++;
    endtask

    task automatic send_frame();
        foreach (tx_frame[i])
            send_byte(tx_frame[i]);
    endtask

    function automatic void fill_frame(input logic [31:0] head, input logic [31:0] foot,
                                       input logic [7:0] len_byte);
        int k;
        tx_frame.delete();
        for (k = 3; k >= 0; k--)
            tx_frame.insert(tx_frame.size(), head[8*k +: 8]);
        tx_frame.insert(tx_frame.size(), len_byte);
        tx_frame.insert(tx_frame.size(), 8'h00);
        for (k = 0; k < int'(len_byte); k++)
            tx_frame.insert(tx_frame.size(), 8'($urandom_range(255)));
        for (k = 3; k >= 0; k--)
            tx_frame.insert(tx_frame.size(), foot[8*k +: 8]);
    endfunction

    function automatic void build_target(input bit eng, input logic [7:0] tgt_state,
                                         input logic [7:0] mov_max, input logic [7:0] sta_max);
        fill_frame(rfr_pkg::TGT_HEAD, rfr_pkg::TGT_FOOT,
                   eng ? rfr_pkg::LEN_ENG : rfr_pkg::LEN_BASIC);
        tx_frame[6] = eng ? rfr_pkg::TYPE_ENG : rfr_pkg::TYPE_BASIC;
        tx_frame[8] = tgt_state;
        if (eng) begin
            tx_frame[17] = mov_max;
            tx_frame[18] = sta_max;
            tx_frame[39] = rfr_pkg::TAIL_MARK;
        end else begin
            tx_frame[17] = rfr_pkg::TAIL_MARK;
        end
    endfunction

    function automatic void build_config(input logic [7:0] len_byte, input logic [7:0] cmd);
        fill_frame(rfr_pkg::CFG_HEAD, rfr_pkg::CFG_FOOT, len_byte);
        tx_frame[6] = cmd;
    endfunction

    function automatic logic [7:0] random_gate_max();
        return ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(9));
    endfunction

    task automatic random_frame();
        int pick, cut;
        logic [7:0] tgt_state;
        pick = $urandom_range(99);
        tgt_state = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        if (pick < 30) begin
            build_target(1'b1, tgt_state, random_gate_max(), random_gate_max());
        end else if (pick < 45) begin
            build_target(1'b0, tgt_state, '0, '0);
        end else if (pick < 58) begin
            build_config(($urandom_range(3) == 0) ? 8'($urandom_range(1, 54)) : 8'h1C,
                         rfr_pkg::CMD_PARAM);
        end else if (pick < 68) begin
            build_config(8'($urandom_range(1, 12)), rfr_pkg::CMD_ACK);
        end else if (pick < 73) begin
            build_config(8'($urandom_range(1, 54)), 8'($urandom_range(255)));
        end else if (pick < 85) begin
            build_target(1'($urandom_range(1)), tgt_state, random_gate_max(),
                         random_gate_max());
            if ($urandom_range(1)) begin
                cut = $urandom_range(4, tx_frame.size() - 1);
                tx_frame[cut] = tx_frame[cut] ^ 8'($urandom_range(1, 255));
            end else begin
                cut = $urandom_range(5, tx_frame.size() - 2);
                while (tx_frame.size() > cut)
                    void'(tx_frame.pop_back());
            end
        end else if (pick < 95) begin
            tx_frame.delete();
            repeat ($urandom_range(1, 8))
                tx_frame.insert(tx_frame.size(), 8'($urandom_range(255)));
        end else begin
            // length byte too large for the store
            fill_frame($urandom_range(1) ? rfr_pkg::TGT_HEAD : rfr_pkg::CFG_HEAD,
                       rfr_pkg::TGT_FOOT, 8'($urandom_range(55, 255)));
            cut = $urandom_range(6, 12);
            while (tx_frame.size() > cut)
                void'(tx_frame.pop_back());
        end
        send_frame();
    endtask

    // tests

    task automatic test_basic_report();
        int k;
        build_target(1'b0, 8'h01, '0, '0);
        for (k = 9; k <= 16; k++)
            tx_frame[k] = 8'hFF;
        send_frame();
    endtask

    task automatic test_engineering_report();
        int k;
        build_target(1'b1, 8'h02, 8'd8, 8'd8);
        for (k = 19; k <= 36; k++)
            tx_frame[k] = 8'h00;
        tx_frame[37] = 8'hFF;
        tx_frame[38] = 8'h01;
        send_frame();
    endtask

    task automatic test_config_frames();
        build_config(8'h1C, rfr_pkg::CMD_PARAM);
        send_frame();
        build_config(8'h04, rfr_pkg::CMD_ACK);
        send_frame();
        // short parameter frame reads stale store bytes
        build_config(8'h02, rfr_pkg::CMD_PARAM);
        send_frame();
    endtask

    task automatic test_malformed_frames();
        send_byte(8'h00);
        send_byte(8'hFF);
        // partial header ahead of a frame
        send_byte(8'hF4);
        send_byte(8'hF3);
        // new header in the middle of a frame
        build_target(1'b1, 8'h01, 8'd2, 8'd2);
        while (tx_frame.size() > 12)
            void'(tx_frame.pop_back());
        send_frame();
        build_config(8'h04, rfr_pkg::CMD_ACK);
        send_frame();
        // bad footer
        build_config(8'h04, rfr_pkg::CMD_ACK);
        tx_frame[tx_frame.size() - 1] = tx_frame[tx_frame.size() - 1] ^ 8'h01;
        send_frame();
        // length byte too large for the store
        fill_frame(rfr_pkg::CFG_HEAD, rfr_pkg::CFG_FOOT, 8'(rfr_pkg::BUFFER_BYTES - 9));
        while (tx_frame.size() > 6)
            void'(tx_frame.pop_back());
        send_frame();
    endtask

    task automatic test_back_to_back();
        steady_mode = 1'b1;
        build_target(1'b0, 8'h00, '0, '0);
        send_frame();
        build_config(8'h04, rfr_pkg::CMD_ACK);
        send_frame();
        steady_mode = 1'b0;
    endtask

    task automatic test_random_traffic();
        do
            random_frame();
        while (bytes_accepted < BYTE_TARGET);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        test_basic_report();
        test_engineering_report();
        test_config_frames();
        test_malformed_frames();
        test_back_to_back();
        test_random_traffic();
        @(negedge aclk) s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
